>>> hdl/mh2_pkg.sv
package mh2_pkg;

	localparam logic [31:0] MH_DEFAULT_SEED = 32'h9747_b28c;
	localparam logic [31:0] MH_MULT         = 32'h5bd1_e995;
	localparam int          MH_WORD_SHIFT   = 24;
	localparam int          MH_FIN_SHIFT_A  = 13;
	localparam int          MH_FIN_SHIFT_B  = 15;

	localparam int          CFG_IDX_W       = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOLD = 8'd1;

	// one queue entry: the work that a single key beat hands to the back end
	typedef struct packed {
		logic        start;     // first beat of a key: load seed_len into the hash
		logic        mix;       // a full word is ready in word
		logic        last;      // finish the key and emit the hash
		logic        tail;      // 1 to 3 leftover bytes sit in word
		logic [31:0] seed_len;  // effective seed xor key length
		logic [31:0] word;      // complete word or tail bytes, little-endian
	} mh2_cmd_t;

endpackage

>>> hdl/mh2_front.sv
module mh2_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              byte_present,
	input  logic [31:0]       key_length,
	input  logic              last_byte,
	input  logic [31:0]       seed,
	input  logic              fold_case,
	input  logic              q_full,
	output logic              q_push,
	output mh2_pkg::mh2_cmd_t q_data
);
	import mh2_pkg::*;

	logic        inside_q;
	logic [1:0]  phase_q;
	logic [31:0] word_q;

	logic        accept;
	logic [7:0]  byte_f;
	logic [31:0] word_n;
	logic [1:0]  phase_n;
	logic [31:0] eff_seed;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign eff_seed = (seed == 32'd0) ? MH_DEFAULT_SEED : seed;

	always_comb begin
		byte_f = data_byte;
		if (fold_case && (data_byte inside {[8'h41:8'h5a]})) begin
			byte_f = data_byte + 8'h20;
		end
		word_n  = word_q;
		phase_n = phase_q;
		if (byte_present) begin
			word_n  = word_q | ({24'd0, byte_f} << {phase_q, 3'b000});
			phase_n = phase_q + 2'd1;
		end
	end

	always_comb begin
		q_data.start    = !inside_q;
		q_data.mix      = byte_present && (phase_q == 2'd3);
		q_data.last     = last_byte;
		q_data.tail     = (phase_n != 2'd0);
		q_data.seed_len = eff_seed ^ key_length;
		q_data.word     = word_n;
	end

	// beats that only add a byte to the partial word need no entry
	assign q_push = accept && (q_data.start || q_data.mix || q_data.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			phase_q  <= 2'd0;
			word_q   <= 32'd0;
		end else if (accept) begin
			if (last_byte) begin
				inside_q <= 1'b0;
				phase_q  <= 2'd0;
				word_q   <= 32'd0;
			end else begin
				inside_q <= 1'b1;
				phase_q  <= phase_n;
				word_q   <= q_data.mix ? 32'd0 : word_n;
			end
		end
	end

endmodule

>>> hdl/mh2_queue.sv
// DEPTH must be 2 or more
module mh2_queue #(
	parameter int DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  mh2_pkg::mh2_cmd_t              push_data,
	output logic                           full,
	output logic                           empty,
	input  logic                           pop,
	output mh2_pkg::mh2_cmd_t              pop_data,
	output logic [$clog2(DEPTH+1)-1:0]     count
);
	import mh2_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	mh2_cmd_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign count    = count_q;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/mh2_back.sv
module mh2_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  mh2_pkg::mh2_cmd_t q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       hash_value
);
	import mh2_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MIX_A,
		B_MIX_B,
		B_MIX_C,
		B_TAIL,
		B_AVAL,
		B_EMIT
	} back_state_t;

	back_state_t state_q;
	mh2_cmd_t    cmd_q;
	logic [31:0] h_q;
	logic [31:0] t_q;
	logic [31:0] out_q;
	logic        out_valid_q;

	logic [31:0] mul_a;
	logic [31:0] mul_p;

	assign q_pop      = (state_q == B_IDLE) && !q_empty;
	assign out_valid  = out_valid_q;
	assign hash_value = out_q;

	// single shared multiplier by the mix constant
	always_comb begin
		case (state_q)
			B_MIX_A: mul_a = cmd_q.word;
			B_MIX_B: mul_a = t_q ^ (t_q >> MH_WORD_SHIFT);
			B_MIX_C: mul_a = h_q;
			B_TAIL:  mul_a = h_q ^ cmd_q.word;
			B_AVAL:  mul_a = h_q ^ (h_q >> MH_FIN_SHIFT_A);
			default: mul_a = h_q;
		endcase
	end

	assign mul_p = mul_a * MH_MULT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cmd_q       <= '0;
			h_q         <= '0;
			t_q         <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in B_EMIT the output register is handled by that state alone
			if (out_valid_q && out_ready && (state_q != B_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						cmd_q <= q_data;
						if (q_data.start) begin
							h_q <= q_data.seed_len;
						end
						if (q_data.mix) begin
							state_q <= B_MIX_A;
						end else if (q_data.last) begin
							state_q <= q_data.tail ? B_TAIL : B_AVAL;
						end
					end
				end
				B_MIX_A: begin
					t_q     <= mul_p;
					state_q <= B_MIX_B;
				end
				B_MIX_B: begin
					t_q     <= mul_p;
					state_q <= B_MIX_C;
				end
				B_MIX_C: begin
					h_q <= mul_p ^ t_q;
					if (cmd_q.last) begin
						state_q <= cmd_q.tail ? B_TAIL : B_AVAL;
					end else begin
						state_q <= B_IDLE;
					end
				end
				B_TAIL: begin
					h_q     <= mul_p;
					state_q <= B_AVAL;
				end
				B_AVAL: begin
					h_q     <= mul_p;
					state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= h_q ^ (h_q >> MH_FIN_SHIFT_B);
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/murmur2_byte_stream_hash.sv
// 32-bit MurmurHash2 over a key streamed one byte per beat.
// Input stream: one beat per key byte, little-endian word assembly. tlast marks
// the key's final beat; tuser says whether the beat carries a byte (an empty
// key is a single beat with tuser low and tlast high). key_length is sampled
// on the first beat of a key only. Output stream: one beat per key, the hash.
// Config channel: index 0 is the seed (zero selects 0x9747b28c), index 1 the
// ASCII fold-to-lower-case enable; other indexes are dropped. Always ready.
// Throughput: a byte beat is taken every cycle while the command queue has
// room. The back end runs one shared multiplier: a word takes it a pop
// plus three multiplies, so a byte per cycle is sustained over a key.
// Ending a key takes the back end through tail (if bytes are left over),
// avalanche and emit.
// Reset: seed and fold_case return to their defaults, the queue empties and
// no key is in progress. A stalled output holds its hash; the back end then
// waits, the queue fills and s_tready drops.
module murmur2_byte_stream_hash #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [7:0] data_byte, [39:8] key_length
	input  logic        s_tuser,   // [0] byte_present
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] hash_value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import mh2_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [31:0] seed_q;
	logic        fold_q;

	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;
	logic [CW-1:0] q_count;
	mh2_cmd_t    q_in;
	mh2_cmd_t    q_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= MH_DEFAULT_SEED;
			fold_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SEED: seed_q <= cfg_data;
				CFG_FOLD: fold_q <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	// front: case fold, word assembly, key start/finish classification
	mh2_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.data_byte    (s_tdata[7:0]),
		.byte_present (s_tuser),
		.key_length   (s_tdata[39:8]),
		.last_byte    (s_tlast),
		.seed         (seed_q),
		.fold_case    (fold_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_in)
	);

	mh2_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.empty     (q_empty),
		.pop       (q_pop),
		.pop_data  (q_out),
		.count     (q_count)
	);

	// back: word mix, tail, avalanche and output register
	mh2_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_out),
		.q_pop      (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.hash_value (m_tdata)
	);

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue overflow");

	// no pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue underflow");

	// simultaneous push and pop leaves the fill level unchanged
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_pop) |=> (q_count == $past(q_count)))
		else $error("queue fill level moved on push and pop");

endmodule
